### sv/pmtm_pkg.sv
// pmtm_pkg: shared types, codes and constants of the particulate frame parser
// and trimmed-mean block; no dependencies
`timescale 1ns / 1ps

package pmtm_pkg;

	localparam int BODY_BYTES_DEF = 8;
	localparam int CNT_W = 32;
	localparam int PM_W = 16;
	localparam int VAL_W = 23;
	localparam int DIV_W = 36;
	localparam int CFG_W = 32;

	localparam logic [7:0] HDR_FIRST = 8'hAA;
	localparam logic [7:0] HDR_SECOND = 8'hC0;
	localparam logic [PM_W-1:0] LOW_RESET = 16'd20000;
	localparam logic [VAL_W-1:0] MEAN_MAX = 23'd6553500;
	localparam logic [CFG_W-1:0] INTERVAL_RESET = 32'd145000;
	localparam logic [CFG_W-1:0] READING_RESET = 32'd5000;

	localparam logic REG_INTERVAL = 1'b0;
	localparam logic REG_READING = 1'b1;

	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_REPORT = 1'b1;

	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_SECOND,
		PH_BODY
	} parse_phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PARSE,
		ST_CHECK,
		ST_TRIM_LOW,
		ST_TRIM_HIGH,
		ST_DIV10_GO,
		ST_DIV10_WAIT,
		ST_DIV25_GO,
		ST_DIV25_WAIT,
		ST_FINISH
	} seq_state_t;

	typedef struct packed {
		logic done;
		logic ok;
		logic [PM_W-1:0] p10;
		logic [PM_W-1:0] p25;
	} frame_t;

	typedef struct packed {
		logic done;
		logic [DIV_W-1:0] quot;
	} div_result_t;

endpackage

### sv/pmtm_parser.sv
// pmtm_parser: header hunt, body byte store and checksum check
// depends on pmtm_pkg
`timescale 1ns / 1ps

module pmtm_parser #(
	parameter int BODY_BYTES = pmtm_pkg::BODY_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic byte_en,
	input  logic [7:0] rx_byte,
	output pmtm_pkg::frame_t frame
);
	import pmtm_pkg::*;

	localparam int IDX_W = $clog2(BODY_BYTES);

	parse_phase_t phase_q, phase_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [7:0] body_q [BODY_BYTES];
	logic [7:0] sum8;
	logic last_byte;
	logic done_s1;
	logic ok_s1;
	logic [PM_W-1:0] p10_s1;
	logic [PM_W-1:0] p25_s1;

	assign last_byte = (phase_q == PH_BODY) && (idx_q == IDX_W'(BODY_BYTES - 1));

	always_comb begin
		sum8 = '0;
		for (int j = 0; j < 6; j++) begin
			sum8 = sum8 + body_q[j];
		end
	end

	always_comb begin
		phase_d = phase_q;
		idx_d = idx_q;
		if (byte_en) begin
			unique case (phase_q)
				PH_BODY: begin
					if (last_byte) begin
						phase_d = PH_HUNT;
						idx_d = '0;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
				PH_SECOND: begin
					if (rx_byte == HDR_SECOND) begin
						phase_d = PH_BODY;
						idx_d = '0;
					end else if (rx_byte != HDR_FIRST) begin
						phase_d = PH_HUNT;
					end
				end
				default: begin
					phase_d = (rx_byte == HDR_FIRST) ? PH_SECOND : PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			idx_q <= '0;
			done_s1 <= 1'b0;
		end else begin
			phase_q <= phase_d;
			idx_q <= idx_d;
			done_s1 <= byte_en && last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_en && (phase_q == PH_BODY)) begin
			body_q[idx_q] <= rx_byte;
		end
		if (byte_en && last_byte) begin
			ok_s1 <= (sum8 == body_q[6]);
			p25_s1 <= {body_q[1], body_q[0]};
			p10_s1 <= {body_q[3], body_q[2]};
		end
	end

	assign frame = {done_s1, ok_s1, p10_s1, p25_s1};

endmodule

### sv/pmtm_div.sv
// pmtm_div: restoring divider, one quotient bit per cycle
// depends on pmtm_pkg
`timescale 1ns / 1ps

module pmtm_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [pmtm_pkg::DIV_W-1:0] dividend,
	input  logic [pmtm_pkg::CNT_W-1:0] divisor,
	output pmtm_pkg::div_result_t result
);
	import pmtm_pkg::*;

	localparam int STEP_W = $clog2(DIV_W);

	logic busy_q;
	logic done_q;
	logic [STEP_W-1:0] step_q;
	logic [DIV_W-1:0] dvd_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] dvs_q;
	logic [CNT_W:0] trial;
	logic [CNT_W:0] diff;
	logic qbit;

	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign diff = trial - {1'b0, dvs_q};
	assign qbit = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], qbit};
			rem_q <= qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	assign result = {done_q, dvd_q};

endmodule

### sv/pm_sensor_frame_trimmed_mean.sv
// pm_sensor_frame_trimmed_mean: top level, sequencer, accumulators and result register
// depends on pmtm_pkg, pmtm_parser, pmtm_div
`timescale 1ns / 1ps
//
// Input stream (s_*): one transfer is one item. s_tuser = 0 carries a received
// serial byte, s_tuser = 1 asks for a report closing the interval. Bytes are
// scanned for the two-byte header, then an eight-byte body is collected; the
// last body byte yields a frame result. A report yields one result with the
// trimmed floor means in tenths, window flags and the running error count.
// Output stream (m_*): m_tuser tells a frame result from a report result.
// A byte passes the parse and check states to the result on m_*, and the
// sequencer then returns to idle. A report passes the trim states and the
// shared 36-step divider, run once for each of the two means; a report with
// no frames left skips both divisions.
// s_tready is high only when the sequencer is idle and the result register is
// empty or being emptied; a stalled receiver holds the result and the block.
// Reset clears parse state, accumulators, error count and loads register
// defaults; there is no clearing pass. cfg_* writes reach the window
// threshold via the interval/reading registers, then the threshold register.
//

module pm_sensor_frame_trimmed_mean #(
	parameter int BODY_BYTES = pmtm_pkg::BODY_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [39:0] s_tdata, // rx_byte[7:0], elapsed_ms[39:8]
	input  logic s_tuser,        // action
	output logic m_tvalid,
	input  logic m_tready,
	// frame_ok[0], frame_counted[1], pm10_value[24:2], pm25_value[47:25],
	// report_valid[48], report_short[49], error_total[81:50], zero fill
	output logic [87:0] m_tdata,
	output logic m_tuser,        // kind
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [pmtm_pkg::CFG_W-1:0] cfg_wdata
);
	import pmtm_pkg::*;

	seq_state_t state_q, state_d;

	logic [CFG_W-1:0] interval_q;
	logic [CFG_W-1:0] reading_q;
	logic [CFG_W-1:0] thresh_q;

	logic action_q;
	logic [7:0] byte_q;
	logic [31:0] elapsed_q;

	logic [CNT_W-1:0] pm10_total_q;
	logic [CNT_W-1:0] pm25_total_q;
	logic [CNT_W-1:0] sample_count_q;
	logic [PM_W-1:0] pm10_low_q;
	logic [PM_W-1:0] pm10_high_q;
	logic [PM_W-1:0] pm25_low_q;
	logic [PM_W-1:0] pm25_high_q;
	logic [CNT_W-1:0] error_q;
	logic [VAL_W-1:0] mean10_q;
	logic [VAL_W-1:0] mean25_q;

	logic out_valid_q;
	logic out_kind_q;
	logic [81:0] out_data_q;

	logic accept;
	logic byte_en;
	logic div_start;
	logic [CNT_W-1:0] div_total;
	logic [DIV_W-1:0] div_dividend;
	logic [VAL_W-1:0] div_sat;
	logic counted;
	logic trim_en;
	logic shrt;
	logic [CNT_W-1:0] error_next;
	frame_t frame;
	div_result_t div_res;

	pmtm_parser #(
		.BODY_BYTES(BODY_BYTES)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.byte_en(byte_en),
		.rx_byte(byte_q),
		.frame(frame)
	);

	pmtm_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(sample_count_q),
		.result(div_res)
	);

	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign accept = s_tvalid && s_tready;

	assign div_total = (state_q == ST_DIV25_GO) ? pm25_total_q : pm10_total_q;
	assign div_dividend = ({4'b0, div_total} << 3) + ({4'b0, div_total} << 1);
	assign div_sat = (div_res.quot > DIV_W'(MEAN_MAX)) ? MEAN_MAX : div_res.quot[VAL_W-1:0];

	assign counted = frame.ok && (elapsed_q > thresh_q);
	assign trim_en = (sample_count_q > CNT_W'(2));
	assign shrt = (sample_count_q < CNT_W'(3));
	assign error_next = error_q + CNT_W'(shrt);

	always_comb begin
		state_d = state_q;
		byte_en = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_PARSE;
				end
			end
			ST_PARSE: begin
				byte_en = (action_q == ACT_BYTE);
				state_d = (action_q == ACT_REPORT) ? ST_TRIM_LOW : ST_CHECK;
			end
			ST_CHECK: state_d = ST_IDLE;
			ST_TRIM_LOW: state_d = ST_TRIM_HIGH;
			ST_TRIM_HIGH: state_d = ST_DIV10_GO;
			ST_DIV10_GO: begin
				if (sample_count_q == '0) begin
					state_d = ST_FINISH;
				end else begin
					div_start = 1'b1;
					state_d = ST_DIV10_WAIT;
				end
			end
			ST_DIV10_WAIT: begin
				if (div_res.done) begin
					state_d = ST_DIV25_GO;
				end
			end
			ST_DIV25_GO: begin
				div_start = 1'b1;
				state_d = ST_DIV25_WAIT;
			end
			ST_DIV25_WAIT: begin
				if (div_res.done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
			reading_q <= READING_RESET;
			thresh_q <= INTERVAL_RESET - READING_RESET;
		end else begin
			thresh_q <= interval_q - reading_q;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_INTERVAL: interval_q <= cfg_wdata;
					REG_READING: reading_q <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= s_tuser;
			byte_q <= s_tdata[7:0];
			elapsed_q <= s_tdata[39:8];
		end
		if ((state_q == ST_DIV10_WAIT) && div_res.done) begin
			mean10_q <= div_sat;
		end
		if ((state_q == ST_DIV25_WAIT) && div_res.done) begin
			mean25_q <= div_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm10_total_q <= '0;
			pm25_total_q <= '0;
			sample_count_q <= '0;
			pm10_low_q <= LOW_RESET;
			pm10_high_q <= '0;
			pm25_low_q <= LOW_RESET;
			pm25_high_q <= '0;
			error_q <= '0;
		end else begin
			unique case (state_q)
				ST_CHECK: begin
					if (frame.done && counted) begin
						pm10_total_q <= pm10_total_q + CNT_W'(frame.p10);
						pm25_total_q <= pm25_total_q + CNT_W'(frame.p25);
						sample_count_q <= sample_count_q + 1'b1;
						if (frame.p10 < pm10_low_q) pm10_low_q <= frame.p10;
						if (frame.p10 > pm10_high_q) pm10_high_q <= frame.p10;
						if (frame.p25 < pm25_low_q) pm25_low_q <= frame.p25;
						if (frame.p25 > pm25_high_q) pm25_high_q <= frame.p25;
					end
				end
				ST_TRIM_LOW: begin
					if (trim_en) begin
						pm10_total_q <= pm10_total_q - CNT_W'(pm10_low_q);
						pm25_total_q <= pm25_total_q - CNT_W'(pm25_low_q);
					end
				end
				ST_TRIM_HIGH: begin
					if (trim_en) begin
						pm10_total_q <= pm10_total_q - CNT_W'(pm10_high_q);
						pm25_total_q <= pm25_total_q - CNT_W'(pm25_high_q);
						sample_count_q <= sample_count_q - CNT_W'(2);
					end
				end
				ST_FINISH: begin
					error_q <= error_next;
					pm10_total_q <= '0;
					pm25_total_q <= '0;
					sample_count_q <= '0;
					pm10_low_q <= LOW_RESET;
					pm10_high_q <= '0;
					pm25_low_q <= LOW_RESET;
					pm25_high_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (((state_q == ST_CHECK) && frame.done) || (state_q == ST_FINISH)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_CHECK) && frame.done) begin
			out_kind_q <= KIND_FRAME;
			out_data_q <= {error_q, 1'b0, 1'b0, VAL_W'(frame.p25), VAL_W'(frame.p10),
				counted, frame.ok};
		end else if (state_q == ST_FINISH) begin
			out_kind_q <= KIND_REPORT;
			if (sample_count_q == '0) begin
				out_data_q <= {error_next, 1'b1, 1'b0, VAL_W'(0), VAL_W'(0), 1'b0, 1'b0};
			end else begin
				out_data_q <= {error_next, shrt, 1'b1, mean25_q, mean10_q, 1'b0, 1'b0};
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = out_kind_q;
	assign m_tdata = {6'b0, out_data_q};

	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (state_q == ST_IDLE))
		else $error("input ready outside idle");

	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |=> (sample_count_q == '0) && (pm10_total_q == '0))
		else $error("accumulators not cleared after report");

	a_low_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(pm10_low_q <= LOW_RESET) && (pm25_low_q <= LOW_RESET))
		else $error("minimum above its reset value");

	a_div_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DIV10_WAIT) && div_res.done) |=> (state_q == ST_DIV25_GO))
		else $error("second division not started");

	a_start_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (sample_count_q != '0))
		else $error("division started with zero count");

endmodule

### dv/tb_pm_sensor_frame_trimmed_mean.sv
// tb_pm_sensor_frame_trimmed_mean: stream testbench for the frame parser and trimmed-mean block;
// predicts every frame and report result, checks them per field under random stalls
// depends on pmtm_pkg and pm_sensor_frame_trimmed_mean
`timescale 1ns / 1ps

module tb_pm_sensor_frame_trimmed_mean;
	import pmtm_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int LONG_HOLD = 400;
	localparam int DRAIN_CYCLES = 120;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int ITEMS_PER_SETTING = 80;

	typedef struct packed {
		logic action;
		logic [7:0] rx_byte;
		logic [31:0] elapsed_ms;
	} sensor_item_t;

	typedef struct packed {
		logic kind;
		logic frame_ok;
		logic frame_counted;
		logic [VAL_W-1:0] pm10_value;
		logic [VAL_W-1:0] pm25_value;
		logic report_valid;
		logic report_short;
		logic [31:0] error_total;
	} pm_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [39:0] s_tdata = '0;    // rx_byte[7:0], elapsed_ms[39:8]
	logic s_tuser = 1'b0;         // action
	logic m_tvalid;
	logic m_tready = 1'b0;
	// frame_ok[0], frame_counted[1], pm10_value[24:2], pm25_value[47:25],
	// report_valid[48], report_short[49], error_total[81:50], zero fill
	logic [87:0] m_tdata;
	logic m_tuser;                // kind
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	sensor_item_t sensor_items[$];
	pm_result_t predicted_results[$];
	pm_result_t next_result;
	pm_result_t oldest_result;

	// predictor state
	logic [31:0] win_interval;
	logic [31:0] win_reading;
	parse_phase_t parse_st;
	int unsigned body_pos;
	logic [7:0] body_mem [0:BODY_BYTES_DEF-1];
	logic [31:0] sum10;
	logic [31:0] sum25;
	logic [31:0] n_frames;
	logic [15:0] lo10;
	logic [15:0] hi10;
	logic [15:0] lo25;
	logic [15:0] hi25;
	logic [31:0] err_count;

	int unsigned fails = 0;
	int unsigned send_gap = 0;
	int unsigned recv_gap = 0;
	int unsigned hold_left = 0;
	int unsigned hold_asks = 0;
	int unsigned hold_served = 0;
	int unsigned quiet_cycles = 0;
	bit no_gaps = 1'b0;

	pm_sensor_frame_trimmed_mean u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #(HALF_PERIOD) clk = ~clk;

	function automatic void clear_window();
		sum10 = '0;
		sum25 = '0;
		n_frames = '0;
		lo10 = LOW_RESET;
		hi10 = '0;
		lo25 = LOW_RESET;
		hi25 = '0;
	endfunction

	function automatic logic [VAL_W-1:0] floor_mean(input logic [31:0] total,
			input logic [31:0] cnt);
		logic [63:0] q;
		q = ({32'd0, total} * 64'd10) / {32'd0, cnt};
		if (q > {41'd0, MEAN_MAX})
			return MEAN_MAX;
		return q[VAL_W-1:0];
	endfunction

	function automatic bit parse_and_average(input logic act, input logic [7:0] b,
			input logic [31:0] el, output pm_result_t r);
		logic [7:0] sum8;
		logic [15:0] p10;
		logic [15:0] p25;
		logic ok;
		r = '0;
		if (act == ACT_REPORT) begin
			r.kind = KIND_REPORT;
			r.report_short = 1'b1;
			if (n_frames > 2) begin
				sum10 = sum10 - {16'd0, lo10} - {16'd0, hi10};
				sum25 = sum25 - {16'd0, lo25} - {16'd0, hi25};
				n_frames = n_frames - 2;
			end
			if (n_frames > 0) begin
				r.report_valid = 1'b1;
				r.pm10_value = floor_mean(sum10, n_frames);
				r.pm25_value = floor_mean(sum25, n_frames);
				r.report_short = (n_frames < 3);
			end
			if (r.report_short)
				err_count = err_count + 1;
			clear_window();
			r.error_total = err_count;
			return 1'b1;
		end
		if (parse_st == PH_BODY) begin
			body_mem[body_pos] = b;
			body_pos++;
			if (body_pos < BODY_BYTES_DEF)
				return 1'b0;
			body_pos = 0;
			parse_st = PH_HUNT;
			sum8 = '0;
			for (int i = 0; i < 6; i++)
				sum8 = sum8 + body_mem[i];
			ok = (sum8 == body_mem[6]);
			p25 = {body_mem[1], body_mem[0]};
			p10 = {body_mem[3], body_mem[2]};
			r.kind = KIND_FRAME;
			r.frame_ok = ok;
			r.pm10_value = {7'd0, p10};
			r.pm25_value = {7'd0, p25};
			if (ok && el > win_interval - win_reading) begin
				r.frame_counted = 1'b1;
				sum10 = sum10 + {16'd0, p10};
				sum25 = sum25 + {16'd0, p25};
				if (p10 < lo10) lo10 = p10;
				if (p10 > hi10) hi10 = p10;
				if (p25 < lo25) lo25 = p25;
				if (p25 > hi25) hi25 = p25;
				n_frames = n_frames + 1;
			end
			r.error_total = err_count;
			return 1'b1;
		end
		if (parse_st == PH_SECOND) begin
			if (b == HDR_SECOND) begin
				parse_st = PH_BODY;
				body_pos = 0;
			end else if (b != HDR_FIRST) begin
				parse_st = PH_HUNT;
			end
			return 1'b0;
		end
		if (b == HDR_FIRST)
			parse_st = PH_SECOND;
		else
			parse_st = PH_HUNT;
		return 1'b0;
	endfunction

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
		fails++;
	endtask

	// sender, with the predictor fed from each input transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			send_gap = 0;
			win_interval = INTERVAL_RESET;
			win_reading = READING_RESET;
			parse_st = PH_HUNT;
			body_pos = 0;
			err_count = '0;
			clear_window();
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_INTERVAL)
					win_interval = cfg_wdata;
				else
					win_interval = win_interval;
				if (cfg_index == REG_READING)
					win_reading = cfg_wdata;
			end
			if (s_tvalid && s_tready) begin
				if (parse_and_average(s_tuser, s_tdata[7:0], s_tdata[39:8], next_result))
					predicted_results.push_back(next_result);
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap != 0) begin
					send_gap = send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (sensor_items.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tuser <= sensor_items[0].action;
					s_tdata <= {sensor_items[0].elapsed_ms, sensor_items[0].rx_byte};
					void'(sensor_items.pop_front());
					send_gap = idle_len();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver and result check
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap = 0;
			hold_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (predicted_results.size() == 0) begin
					flag_mismatch("result with none pending", {31'd0, m_tuser}, 32'd0);
				end else begin
					oldest_result = predicted_results.pop_front();
					if (m_tuser !== oldest_result.kind)
						flag_mismatch("kind", 32'(m_tuser), 32'(oldest_result.kind));
					if (m_tdata[0] !== oldest_result.frame_ok)
						flag_mismatch("frame_ok", 32'(m_tdata[0]),
							32'(oldest_result.frame_ok));
					if (m_tdata[1] !== oldest_result.frame_counted)
						flag_mismatch("frame_counted", 32'(m_tdata[1]),
							32'(oldest_result.frame_counted));
					if (m_tdata[24:2] !== oldest_result.pm10_value)
						flag_mismatch("pm10_value", 32'(m_tdata[24:2]),
							32'(oldest_result.pm10_value));
					if (m_tdata[47:25] !== oldest_result.pm25_value)
						flag_mismatch("pm25_value", 32'(m_tdata[47:25]),
							32'(oldest_result.pm25_value));
					if (m_tdata[48] !== oldest_result.report_valid)
						flag_mismatch("report_valid", 32'(m_tdata[48]),
							32'(oldest_result.report_valid));
					if (m_tdata[49] !== oldest_result.report_short)
						flag_mismatch("report_short", 32'(m_tdata[49]),
							32'(oldest_result.report_short));
					if (m_tdata[81:50] !== oldest_result.error_total)
						flag_mismatch("error_total", m_tdata[81:50], oldest_result.error_total);
				end
			end
			if (hold_served != hold_asks) begin
				hold_served = hold_asks;
				hold_left = LONG_HOLD;
				m_tready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left = hold_left - 1;
				m_tready <= 1'b0;
			end else if (recv_gap != 0) begin
				recv_gap = recv_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				recv_gap = idle_len();
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quiet_cycles <= 0;
		else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("FAIL");
		$finish;
	end

	task automatic queue_item(input logic act, input logic [7:0] b, input logic [31:0] el);
		sensor_item_t it;
		it.action = act;
		it.rx_byte = b;
		it.elapsed_ms = el;
		sensor_items.push_back(it);
	endtask

	task automatic queue_frame(input logic [15:0] p25, input logic [15:0] p10, input bit bad,
			input logic [31:0] el_last);
		logic [7:0] body [0:7];
		logic [7:0] cks;
		body[0] = p25[7:0];
		body[1] = p25[15:8];
		body[2] = p10[7:0];
		body[3] = p10[15:8];
		body[4] = 8'($urandom_range(0, 255));
		body[5] = 8'($urandom_range(0, 255));
		cks = '0;
		for (int i = 0; i < 6; i++)
			cks = cks + body[i];
		body[6] = bad ? cks ^ 8'($urandom_range(1, 255)) : cks;
		body[7] = 8'($urandom_range(0, 255));
		queue_item(ACT_BYTE, HDR_FIRST, $urandom);
		queue_item(ACT_BYTE, HDR_SECOND, $urandom);
		for (int i = 0; i < 7; i++)
			queue_item(ACT_BYTE, body[i], $urandom);
		queue_item(ACT_BYTE, body[7], el_last);
	endtask

	function automatic logic [15:0] pick_pm();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(19998, 20002));
			3: return 16'($urandom_range(0, 65535));
			default: return 16'($urandom_range(0, 1500));
		endcase
	endfunction

	// last-byte time inside or outside the accumulation window
	function automatic logic [31:0] pick_elapsed(input bit in_window);
		logic [31:0] thr;
		int unsigned r;
		thr = win_interval - win_reading;
		r = $urandom_range(0, 9);
		if (in_window && thr != 32'hFFFFFFFF) begin
			if (r == 0)
				return thr + 1;
			if (r == 1)
				return 32'hFFFFFFFF;
			return $urandom_range(32'hFFFFFFFF, thr + 1);
		end
		if (r == 0)
			return thr;
		if (r == 1)
			return 32'd0;
		return $urandom_range(thr, 0);
	endfunction

	task automatic write_reg(input logic idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (sensor_items.size() != 0 || s_tvalid || predicted_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_setting(input logic [31:0] ivl, input logic [31:0] rdg,
			input int unsigned rep_pct, input bit steady, input bit squeeze);
		int unsigned made;
		int unsigned r;
		int unsigned k;
		write_reg(REG_INTERVAL, ivl);
		write_reg(REG_READING, rdg);
		@(negedge clk);
		no_gaps <= steady;
		made = 0;
		while (made < ITEMS_PER_SETTING) begin
			r = $urandom_range(0, 99);
			if (r < rep_pct) begin
				queue_item(ACT_REPORT, 8'($urandom_range(0, 255)), $urandom);
				made++;
			end else if (r < rep_pct + 10) begin
				// stray bytes between frames
				queue_item(ACT_BYTE, ($urandom_range(0, 3) == 0) ? HDR_FIRST :
					8'($urandom_range(0, 255)), $urandom);
			end else if (r < rep_pct + 18) begin
				// broken frame: header then a cut body
				k = $urandom_range(0, 7);
				queue_item(ACT_BYTE, HDR_FIRST, $urandom);
				queue_item(ACT_BYTE, (k == 0) ? HDR_FIRST : HDR_SECOND, $urandom);
				for (int i = 0; i < k; i++)
					queue_item(ACT_BYTE, 8'($urandom_range(0, 255)), $urandom);
				made += k + 2;
			end else begin
				queue_frame(pick_pm(), pick_pm(), $urandom_range(0, 5) == 0,
					pick_elapsed($urandom_range(0, 3) != 0));
				made += 10;
			end
		end
		if (squeeze)
			hold_asks <= hold_asks + 1;
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty report, header hunt cases, report inside a body, bad checksum
		queue_item(ACT_REPORT, 8'h00, 32'd0);
		queue_item(ACT_BYTE, 8'h00, 32'hFFFFFFFF);
		queue_item(ACT_BYTE, HDR_FIRST, 32'd1);
		queue_item(ACT_BYTE, 8'h55, 32'd2);
		queue_item(ACT_BYTE, HDR_FIRST, 32'd3);
		queue_item(ACT_BYTE, HDR_FIRST, 32'd4);
		queue_item(ACT_BYTE, HDR_SECOND, 32'd5);
		repeat (4) queue_item(ACT_BYTE, 8'hFF, 32'd6);
		queue_item(ACT_REPORT, 8'hFF, 32'hFFFFFFFF);
		queue_item(ACT_BYTE, 8'h00, 32'd7);
		queue_item(ACT_BYTE, 8'h00, 32'd8);
		queue_item(ACT_BYTE, 8'hFC, 32'd9);
		queue_item(ACT_BYTE, 8'hFF, 32'hFFFFFFFF);
		queue_frame(16'h0000, 16'h0000, 1'b1, 32'hFFFFFFFF);
		queue_item(ACT_REPORT, 8'h00, 32'd0);
		wait_idle();

		run_setting(INTERVAL_RESET, READING_RESET, 10, 1'b0, 1'b0);
		run_setting(32'd0, 32'd0, 25, 1'b0, 1'b0);
		run_setting(32'hFFFFFFFF, 32'd0, 10, 1'b1, 1'b0);
		run_setting(32'd0, 32'hFFFFFFFF, 15, 1'b0, 1'b1);
		run_setting(32'd1000, 32'd2000, 8, 1'b0, 1'b0);
		run_setting($urandom, $urandom, 12, 1'b0, 1'b1);

		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
